FILE: sv/mra_pkg.sv
`default_nettype none

package mra_pkg;

    // Field widths
    localparam int DATA_W = 64;
    localparam int CMD_W = 4;
    localparam int SLOT_W = 4;
    localparam int STATUS_W = 3;
    localparam int STATE_W = 2;
    localparam int CFG_IDX_W = 2;

    // Slot table depth and the most slots a slot field can address
    localparam int SLOT_COUNT_DEF = 16;
    localparam int SLOT_ADDR_MAX = 1 << SLOT_W;

    // Headroom is budget / 20, capped; budget / 20 never exceeds budget / 2
    localparam int HEADROOM_DIV = 20;
    // budget / 20 is the top bits of budget times this reciprocal
    localparam logic [DATA_W-1:0] HEADROOM_RECIP = 64'hCCCC_CCCC_CCCC_CCCD;
    localparam int HEADROOM_SHIFT = 68;
    localparam int HALF_W = DATA_W / 2;

    // Config write holds off items while the partial products are summed and the limit settles
    localparam int MUL_STEPS = 4;
    localparam int BUSY_START = MUL_STEPS + 2;
    localparam int BUSY_W = $clog2(BUSY_START + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_RESERVE  = 4'd0,
        CMD_GROWTH   = 4'd1,
        CMD_COMMIT   = 4'd2,
        CMD_TRANSFER = 4'd3,
        CMD_DOWNSIZE = 4'd4,
        CMD_ROLLBACK = 4'd5,
        CMD_RELEASE  = 4'd6,
        CMD_MOVE     = 4'd7,
        CMD_CLEAR    = 4'd8
    } t_cmd;

    typedef enum logic [STATE_W-1:0] {
        SS_EMPTY     = 2'd0,
        SS_RESERVED  = 2'd1,
        SS_COMMITTED = 2'd2,
        SS_RELEASED  = 2'd3
    } t_slot_state;

    typedef enum logic [STATUS_W-1:0] {
        RS_OK       = 3'd0,
        RS_ADVISORY = 3'd1,
        RS_DENIED   = 3'd2,
        RS_OVERFLOW = 3'd3,
        RS_INVALID  = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUDGET    = 2'd0,
        CFG_ENFORCING = 2'd1,
        CFG_HEAD_CAP  = 2'd2
    } t_cfg_idx;

    localparam logic [DATA_W-1:0] HEAD_CAP_RESET = 64'd268435456;

endpackage

`default_nettype wire

FILE: sv/mra_in_if.sv
`default_nettype none

interface mra_in_if;
    import mra_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [SLOT_W-1:0]   slot;
    logic [SLOT_W-1:0]   source_slot;
    logic [DATA_W-1:0]   amount;
    logic [DATA_W-1:0]   old_amount;
    logic [DATA_W-1:0]   owner_tag;

    modport source (
        output valid, command, slot, source_slot, amount, old_amount, owner_tag,
        input  ready
    );

    modport sink (
        input  valid, command, slot, source_slot, amount, old_amount, owner_tag,
        output ready
    );

endinterface

`default_nettype wire

FILE: sv/mra_out_if.sv
`default_nettype none

interface mra_out_if;
    import mra_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   reserved_total_out;
    logic [STATE_W-1:0]  slot_state_out;
    logic [DATA_W-1:0]   slot_bytes_out;

    modport source (
        output valid, status, reserved_total_out, slot_state_out, slot_bytes_out,
        input  ready
    );

    modport sink (
        input  valid, status, reserved_total_out, slot_state_out, slot_bytes_out,
        output ready
    );

endinterface

`default_nettype wire

FILE: sv/memory_reservation_admission_core.sv
`default_nettype none

// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    command, slot, source_slot, amount, old_amount, owner_tag
// o_out     out  valid/ready    status, reserved_total_out, slot_state_out, slot_bytes_out
// i_cfg_*   in   write enable   register index, 64-bit data
//
// One item per cycle unless a stalled result or a limit refresh holds the input:
// an item is taken into the input register while the slot byte and owner
// memories are read, then is executed and lands in the result register.
// Any configuration write starts a four-step 32 x 32 multiply of the budget by
// the reciprocal of 20; items are held off after the last write until the usable
// limit is refreshed.
// Reset (synchronous, active low) empties every slot at once and clears the
// total; no clearing pass. A stalled result holds the input register.

module memory_reservation_admission_core #(
    parameter int SLOT_COUNT = mra_pkg::SLOT_COUNT_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    mra_in_if.sink                         i_in,
    mra_out_if.source                      o_out,
    input  wire                            i_cfg_we,
    input  wire [mra_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [mra_pkg::DATA_W-1:0]      i_cfg_data
);
    import mra_pkg::*;

    // Only slots a slot field can name get storage
    localparam int DEPTH = (SLOT_COUNT < SLOT_ADDR_MAX) ? SLOT_COUNT : SLOT_ADDR_MAX;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [SLOT_W:0] DEPTH_L = (SLOT_W + 1)'(DEPTH);

    // Configuration and limit
    logic [DATA_W-1:0]    r_budget;
    logic                 r_enforcing;
    logic [DATA_W-1:0]    r_head_cap;
    logic [DATA_W-1:0]    r_limit;
    logic [DATA_W-1:0]    n_limit;
    logic [DATA_W-1:0]    w_headroom;

    // Headroom multiplier
    logic [BUSY_W-1:0]    r_busy_cnt;
    logic [DATA_W-1:0]    r_div_x;
    logic [2*DATA_W-1:0]  r_prod_acc;
    logic [1:0]           w_mul_sel;
    logic [HALF_W-1:0]    w_mul_a;
    logic [HALF_W-1:0]    w_mul_b;
    logic [DATA_W-1:0]    w_part;
    logic [2*DATA_W-1:0]  w_part_sh;
    logic [DATA_W-1:0]    w_quo;
    logic                 w_div_step;

    // Input register
    logic                 r_in_valid;
    t_cmd                 r_cmd;
    logic [SLOT_W-1:0]    r_slot;
    logic [SLOT_W-1:0]    r_src;
    logic [DATA_W-1:0]    r_amount;
    logic [DATA_W-1:0]    r_old_amount;
    logic [DATA_W-1:0]    r_owner_tag;

    // Slot table: state in flops, bytes and owner in memories
    t_slot_state          r_state [DEPTH];
    logic [DATA_W-1:0]    r_mem_bytes [DEPTH];
    logic [DATA_W-1:0]    r_mem_owner [DEPTH];
    logic [DATA_W-1:0]    r_rd_bytes_d;
    logic [DATA_W-1:0]    r_rd_bytes_s;
    logic [DATA_W-1:0]    r_rd_owner_d;
    logic [DATA_W-1:0]    r_rd_owner_s;
    logic                 r_byp_d;
    logic                 r_byp_s;
    logic [DATA_W-1:0]    r_byp_bytes;
    logic [DATA_W-1:0]    r_byp_owner;
    logic [DATA_W-1:0]    r_total;

    // Result register
    logic                 r_out_valid;
    t_status              r_status;
    logic [DATA_W-1:0]    r_total_out;
    t_slot_state          r_state_out;
    logic [DATA_W-1:0]    r_bytes_out;

    // Handshake
    logic                 w_busy;
    logic                 w_accept;
    logic                 w_fire;
    logic [IDX_W-1:0]     w_in_idx_d;
    logic [IDX_W-1:0]     w_in_idx_s;

    // Execute stage
    logic [IDX_W-1:0]     w_idx_d;
    logic [IDX_W-1:0]     w_idx_s;
    logic                 w_slot_ok;
    logic                 w_src_ok;
    t_slot_state          w_st_d;
    t_slot_state          w_st_s;
    logic [DATA_W-1:0]    w_bytes_d;
    logic [DATA_W-1:0]    w_bytes_s;
    logic [DATA_W-1:0]    w_owner_d;
    logic [DATA_W-1:0]    w_owner_s;
    logic [DATA_W:0]      w_sum;
    logic [DATA_W-1:0]    w_shrink;
    t_status              n_status;
    logic [DATA_W-1:0]    n_total;
    t_slot_state          n_st_d;
    logic [DATA_W-1:0]    n_bytes_d;
    logic [DATA_W-1:0]    n_owner_d;
    logic                 w_state_we_d;
    logic                 w_state_we_s;
    logic                 w_mem_we;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget    <= '0;
            r_enforcing <= 1'b0;
            r_head_cap  <= HEAD_CAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BUDGET:    r_budget    <= i_cfg_data;
                CFG_ENFORCING: r_enforcing <= i_cfg_data[0];
                CFG_HEAD_CAP:  r_head_cap  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Multiply budget by the reciprocal of 20, one 32 x 32 partial product a cycle
    assign w_div_step = (r_busy_cnt > BUSY_W'(2));
    assign w_mul_sel  = 2'(r_busy_cnt - BUSY_W'(3));
    assign w_mul_a    = w_mul_sel[1] ? r_div_x[DATA_W-1:HALF_W] : r_div_x[HALF_W-1:0];
    assign w_mul_b    = w_mul_sel[0] ? HEADROOM_RECIP[DATA_W-1:HALF_W]
                                     : HEADROOM_RECIP[HALF_W-1:0];
    assign w_part     = {{HALF_W{1'b0}}, w_mul_a} * {{HALF_W{1'b0}}, w_mul_b};

    // Line the partial product up with its weight
    always_comb begin
        case (w_mul_sel)
            2'd0:    w_part_sh = {{DATA_W{1'b0}}, w_part};
            2'd3:    w_part_sh = {w_part, {DATA_W{1'b0}}};
            default: w_part_sh = {{HALF_W{1'b0}}, w_part, {HALF_W{1'b0}}};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_cnt <= '0;
            r_prod_acc <= '0;
        end else if (i_cfg_we) begin
            r_busy_cnt <= BUSY_W'(BUSY_START);
            r_prod_acc <= '0;
        end else begin
            if (r_busy_cnt != '0) begin
                r_busy_cnt <= r_busy_cnt - BUSY_W'(1);
            end
            if (w_div_step) begin
                r_prod_acc <= r_prod_acc + w_part_sh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            r_div_x <= (i_cfg_index == CFG_BUDGET) ? i_cfg_data : r_budget;
        end
    end

    assign w_quo = {{(HEADROOM_SHIFT - DATA_W){1'b0}},
                    r_prod_acc[2*DATA_W-1:HEADROOM_SHIFT]};

    // Refresh the usable limit every cycle
    assign w_headroom = (w_quo > r_head_cap) ? r_head_cap : w_quo;
    assign n_limit    = r_enforcing ? (r_budget - w_headroom) : '1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '1;
        end else begin
            r_limit <= n_limit;
        end
    end

    // Handshake: execute when the result register is free or being taken
    assign w_busy     = (r_busy_cnt != '0);
    assign w_fire     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !w_busy && (!r_in_valid || w_fire);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_in_idx_d = i_in.slot[IDX_W-1:0];
    assign w_in_idx_s = i_in.source_slot[IDX_W-1:0];

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd        <= t_cmd'(i_in.command);
            r_slot       <= i_in.slot;
            r_src        <= i_in.source_slot;
            r_amount     <= i_in.amount;
            r_old_amount <= i_in.old_amount;
            r_owner_tag  <= i_in.owner_tag;
        end
    end

    // Slot memories: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (w_fire && w_mem_we) begin
            r_mem_bytes[w_idx_d] <= n_bytes_d;
            r_mem_owner[w_idx_d] <= n_owner_d;
        end
        if (w_accept) begin
            r_rd_bytes_d <= r_mem_bytes[w_in_idx_d];
            r_rd_bytes_s <= r_mem_bytes[w_in_idx_s];
            r_rd_owner_d <= r_mem_owner[w_in_idx_d];
            r_rd_owner_s <= r_mem_owner[w_in_idx_s];
        end
    end

    // Forward a write that lands in the same cycle as the read
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byp_d     <= w_fire && w_mem_we && (w_idx_d == w_in_idx_d);
            r_byp_s     <= w_fire && w_mem_we && (w_idx_d == w_in_idx_s);
            r_byp_bytes <= n_bytes_d;
            r_byp_owner <= n_owner_d;
        end
    end

    // Operand selection; an empty slot always reads as zero bytes and owner
    assign w_idx_d   = r_slot[IDX_W-1:0];
    assign w_idx_s   = r_src[IDX_W-1:0];
    assign w_slot_ok = ({1'b0, r_slot} < DEPTH_L);
    assign w_src_ok  = ({1'b0, r_src} < DEPTH_L) && (r_src != r_slot);
    assign w_st_d    = w_slot_ok ? r_state[w_idx_d] : SS_EMPTY;
    assign w_st_s    = w_src_ok ? r_state[w_idx_s] : SS_EMPTY;
    assign w_bytes_d = (w_st_d == SS_EMPTY) ? '0 : (r_byp_d ? r_byp_bytes : r_rd_bytes_d);
    assign w_owner_d = (w_st_d == SS_EMPTY) ? '0 : (r_byp_d ? r_byp_owner : r_rd_owner_d);
    assign w_bytes_s = (w_st_s == SS_EMPTY) ? '0 : (r_byp_s ? r_byp_bytes : r_rd_bytes_s);
    assign w_owner_s = (w_st_s == SS_EMPTY) ? '0 : (r_byp_s ? r_byp_owner : r_rd_owner_s);
    assign w_sum     = {1'b0, r_total} + {1'b0, r_amount};
    assign w_shrink  = w_bytes_d - r_amount;

    // Decode the command and work out the new slot and total
    always_comb begin
        n_status     = RS_INVALID;
        n_total      = r_total;
        n_st_d       = w_st_d;
        n_bytes_d    = w_bytes_d;
        n_owner_d    = w_owner_d;
        w_state_we_d = 1'b0;
        w_state_we_s = 1'b0;
        w_mem_we     = 1'b0;
        if (w_slot_ok) begin
            unique case (r_cmd)
                CMD_RESERVE, CMD_GROWTH: begin
                    if (r_amount != '0
                        && (w_st_d == SS_EMPTY || w_st_d == SS_RELEASED)
                        && (r_cmd == CMD_RESERVE || r_amount >= r_old_amount)) begin
                        n_bytes_d    = r_amount;
                        n_owner_d    = '0;
                        w_mem_we     = 1'b1;
                        w_state_we_d = 1'b1;
                        if (w_sum[DATA_W]) begin
                            n_st_d   = SS_RELEASED;
                            n_status = RS_OVERFLOW;
                        end else if (w_sum[DATA_W-1:0] > r_limit) begin
                            n_st_d   = SS_RELEASED;
                            n_status = RS_DENIED;
                        end else begin
                            n_st_d   = SS_RESERVED;
                            n_total  = w_sum[DATA_W-1:0];
                            n_status = r_enforcing ? RS_OK : RS_ADVISORY;
                        end
                    end
                end
                CMD_COMMIT: begin
                    if (w_st_d == SS_RESERVED) begin
                        n_owner_d    = r_owner_tag;
                        n_st_d       = SS_COMMITTED;
                        w_mem_we     = 1'b1;
                        w_state_we_d = 1'b1;
                        n_status     = RS_OK;
                    end
                end
                CMD_TRANSFER: begin
                    if (w_st_d == SS_RESERVED || w_st_d == SS_COMMITTED) begin
                        n_owner_d = r_owner_tag;
                        w_mem_we  = 1'b1;
                        n_status  = RS_OK;
                    end
                end
                CMD_DOWNSIZE: begin
                    if (w_st_d == SS_COMMITTED && r_amount != '0
                        && r_amount <= w_bytes_d && w_shrink <= r_total) begin
                        n_total   = r_total - w_shrink;
                        n_bytes_d = r_amount;
                        w_mem_we  = 1'b1;
                        n_status  = RS_OK;
                    end
                end
                CMD_ROLLBACK, CMD_RELEASE: begin
                    if ((w_st_d == SS_RESERVED
                         || (r_cmd == CMD_RELEASE && w_st_d == SS_COMMITTED))
                        && w_bytes_d != '0 && w_bytes_d <= r_total) begin
                        n_total      = r_total - w_bytes_d;
                        n_st_d       = SS_RELEASED;
                        w_state_we_d = 1'b1;
                        n_status     = RS_OK;
                    end
                end
                CMD_MOVE: begin
                    if (w_src_ok
                        && (w_st_d == SS_EMPTY || w_st_d == SS_RELEASED)
                        && (w_st_s == SS_RESERVED || w_st_s == SS_COMMITTED)) begin
                        n_st_d       = w_st_s;
                        n_bytes_d    = w_bytes_s;
                        n_owner_d    = w_owner_s;
                        w_mem_we     = 1'b1;
                        w_state_we_d = 1'b1;
                        w_state_we_s = 1'b1;
                        n_status     = RS_OK;
                    end
                end
                CMD_CLEAR: begin
                    n_st_d       = SS_EMPTY;
                    n_bytes_d    = '0;
                    n_owner_d    = '0;
                    w_state_we_d = 1'b1;
                    n_status     = RS_OK;
                end
                default: ;
            endcase
        end
    end

    // Commit slot state and total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_state[i] <= SS_EMPTY;
            end
            r_total <= '0;
        end else if (w_fire) begin
            if (w_state_we_s) begin
                r_state[w_idx_s] <= SS_EMPTY;
            end
            if (w_state_we_d) begin
                r_state[w_idx_d] <= n_st_d;
            end
            r_total <= n_total;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status    <= n_status;
            r_total_out <= n_total;
            r_state_out <= n_st_d;
            r_bytes_out <= w_slot_ok ? n_bytes_d : '0;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.status             = r_status;
    assign o_out.reserved_total_out = r_total_out;
    assign o_out.slot_state_out     = r_state_out;
    assign o_out.slot_bytes_out     = r_bytes_out;

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`default_nettype none

module tb_top;
    import mra_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 110;
    localparam int NUM_SETTINGS   = 8;
    localparam int MAX_GAP        = 13;
    localparam int BURST_WINDOW   = 40;
    localparam int LONG_HOLD      = 200;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SMALL_LEAK     = 4;

    localparam logic [DATA_W-1:0] ALL_ONES       = '1;
    localparam logic [CMD_W-1:0]  CMD_UNUSED_LO  = 4'd9;
    localparam logic [CMD_W-1:0]  CMD_UNUSED_HI  = 4'd15;

    typedef struct {
        logic [CMD_W-1:0]  command;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] source_slot;
        logic [DATA_W-1:0] amount;
        logic [DATA_W-1:0] old_amount;
        logic [DATA_W-1:0] owner_tag;
    } cmd_item_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   total;
        logic [STATE_W-1:0]  state;
        logic [DATA_W-1:0]   bytes;
    } reply_t;

    typedef struct {
        logic [DATA_W-1:0] budget;
        logic              enforcing;
        logic [DATA_W-1:0] head_cap;
        logic [DATA_W-1:0] span;
    } setting_t;

    // Slot table mirror, admission arithmetic and the queue of replies owed
    class admission_tracker;
        logic [DATA_W-1:0] budget;
        logic              enforcing;
        logic [DATA_W-1:0] head_cap;
        t_slot_state       slot_st [SLOT_COUNT_DEF];
        logic [DATA_W-1:0] slot_bytes [SLOT_COUNT_DEF];
        logic [DATA_W-1:0] slot_owner [SLOT_COUNT_DEF];
        logic [DATA_W-1:0] total;
        reply_t            expected_replies [$];
        int                mismatches;
        int                status_seen [RS_INVALID+1];

        function new();
            budget     = '0;
            enforcing  = 1'b0;
            head_cap   = HEAD_CAP_RESET;
            total      = '0;
            mismatches = 0;
            for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
                slot_st[i]    = SS_EMPTY;
                slot_bytes[i] = '0;
                slot_owner[i] = '0;
            end
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [DATA_W-1:0] value);
            case (idx)
                CFG_BUDGET:    budget = value;
                CFG_ENFORCING: enforcing = value[0];
                CFG_HEAD_CAP:  head_cap = value;
                default: ;
            endcase
        endfunction

        function bit is_live(int s);
            return slot_st[s] == SS_RESERVED || slot_st[s] == SS_COMMITTED;
        endfunction

        // Budget less the withheld headroom; no limit at all when advisory
        function logic [DATA_W-1:0] usable_limit();
            logic [DATA_W-1:0] head;
            if (!enforcing) return ALL_ONES;
            head = budget / DATA_W'(HEADROOM_DIV);
            if (head > head_cap) head = head_cap;
            if (head > (budget >> 1)) head = budget >> 1;
            return budget - head;
        endfunction

        function logic [DATA_W-1:0] room_left();
            return usable_limit() - total;
        endfunction

        function t_status reserve_bytes(int s, logic [DATA_W-1:0] bytes);
            logic [DATA_W-1:0] sum;
            if (bytes == '0 || is_live(s)) return RS_INVALID;
            slot_bytes[s] = bytes;
            slot_owner[s] = '0;
            // refused bytes stay on the slot, which drops to released
            if (bytes > ALL_ONES - total) begin
                slot_st[s] = SS_RELEASED;
                return RS_OVERFLOW;
            end
            sum = total + bytes;
            if (sum > usable_limit()) begin
                slot_st[s] = SS_RELEASED;
                return RS_DENIED;
            end
            total      = sum;
            slot_st[s] = SS_RESERVED;
            return enforcing ? RS_OK : RS_ADVISORY;
        endfunction

        function t_status finish_slot(int s, bit rollback);
            if (slot_st[s] != SS_RESERVED && (rollback || slot_st[s] != SS_COMMITTED))
                return RS_INVALID;
            if (slot_bytes[s] == '0 || slot_bytes[s] > total) return RS_INVALID;
            total      = total - slot_bytes[s];
            slot_st[s] = SS_RELEASED;
            return RS_OK;
        endfunction

        // Apply one accepted item and queue the reply it owes
        function void note_command(cmd_item_t it);
            reply_t  want;
            t_status st;
            int      s;
            int      r;
            st = RS_INVALID;
            s  = int'(it.slot);
            r  = int'(it.source_slot);
            case (it.command)
                CMD_RESERVE: st = reserve_bytes(s, it.amount);
                CMD_GROWTH: begin
                    if (it.amount >= it.old_amount && !is_live(s))
                        st = reserve_bytes(s, it.amount);
                end
                CMD_COMMIT: begin
                    if (slot_st[s] == SS_RESERVED) begin
                        slot_owner[s] = it.owner_tag;
                        slot_st[s]    = SS_COMMITTED;
                        st            = RS_OK;
                    end
                end
                CMD_TRANSFER: begin
                    if (is_live(s)) begin
                        slot_owner[s] = it.owner_tag;
                        st            = RS_OK;
                    end
                end
                CMD_DOWNSIZE: begin
                    if (slot_st[s] == SS_COMMITTED && it.amount != '0
                            && it.amount <= slot_bytes[s]
                            && slot_bytes[s] - it.amount <= total) begin
                        total         = total - (slot_bytes[s] - it.amount);
                        slot_bytes[s] = it.amount;
                        st            = RS_OK;
                    end
                end
                CMD_ROLLBACK: st = finish_slot(s, 1'b1);
                CMD_RELEASE:  st = finish_slot(s, 1'b0);
                CMD_MOVE: begin
                    if (r != s && !is_live(s) && is_live(r)) begin
                        slot_st[s]    = slot_st[r];
                        slot_bytes[s] = slot_bytes[r];
                        slot_owner[s] = slot_owner[r];
                        slot_st[r]    = SS_EMPTY;
                        slot_bytes[r] = '0;
                        slot_owner[r] = '0;
                        st            = RS_OK;
                    end
                end
                CMD_CLEAR: begin
                    // the total is left alone, even for a live slot
                    slot_st[s]    = SS_EMPTY;
                    slot_bytes[s] = '0;
                    slot_owner[s] = '0;
                    st            = RS_OK;
                end
                default: ;
            endcase
            want.status = st;
            want.total  = total;
            want.state  = slot_st[s];
            want.bytes  = slot_bytes[s];
            status_seen[st]++;
            expected_replies.push_back(want);
        endfunction

        // Compare one reply against the oldest owed
        function void check_reply(reply_t got);
            reply_t want;
            if (expected_replies.size() == 0) begin
                $error("reply arrived with no command outstanding");
                mismatches++;
                return;
            end
            want = expected_replies.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.total !== want.total) begin
                $error("reserved_total_out: expected %0h, got %0h", want.total, got.total);
                mismatches++;
            end
            if (got.state !== want.state) begin
                $error("slot_state_out: expected %0d, got %0d", want.state, got.state);
                mismatches++;
            end
            if (got.bytes !== want.bytes) begin
                $error("slot_bytes_out: expected %0h, got %0h", want.bytes, got.bytes);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_replies.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]    i_cfg_data;

    mra_in_if  cmd_if ();
    mra_out_if reply_if ();

    admission_tracker tracker = new();

    int sent_count   = 0;
    int replies_seen = 0;
    int idle_cycles  = 0;
    int stall_left   = 0;
    bit send_burst   = 1'b0;
    bit take_burst   = 1'b0;
    bit reply_taken  = 1'b0;
    bit hold_request = 1'b0;

    memory_reservation_admission_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (cmd_if),
        .o_out       (reply_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Check replies and watch for a stalled run
    always @(posedge i_clk) begin : reply_check
        reply_t got;
        bit     took;
        took = 1'b0;
        if (i_rst_n === 1'b1 && reply_if.valid === 1'b1 && reply_if.ready === 1'b1) begin
            got.status = reply_if.status;
            got.total  = reply_if.reserved_total_out;
            got.state  = reply_if.slot_state_out;
            got.bytes  = reply_if.slot_bytes_out;
            tracker.check_reply(got);
            replies_seen++;
            reply_taken = 1'b1;
            took        = 1'b1;
        end
        if (took || (cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Reply side back-pressure: a random gap after each reply, or one long hold
    always @(negedge i_clk) begin
        if (hold_request) begin
            stall_left   = LONG_HOLD;
            hold_request = 1'b0;
        end else if (reply_taken) begin
            if (replies_seen % BURST_WINDOW == 0)
                take_burst = ($urandom_range(0, 3) == 0);
            stall_left = take_burst ? 0 : int'($urandom_range(0, MAX_GAP));
        end
        reply_taken = 1'b0;
        if (stall_left > 0) begin
            reply_if.ready <= 1'b0;
            stall_left--;
        end else begin
            reply_if.ready <= 1'b1;
        end
    end

    function automatic logic [DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Uniform value in 0..limit
    function automatic logic [DATA_W-1:0] up_to(logic [DATA_W-1:0] limit);
        if (limit == ALL_ONES) return rand_word();
        return rand_word() % (limit + 1);
    endfunction

    function automatic logic [DATA_W-1:0] pick_amount(logic [DATA_W-1:0] span);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return rand_word() % span + 1;
        if (roll < 68) return '0;
        if (roll < 76) return ALL_ONES;
        if (roll < 86) return rand_word();
        // right at the edge of the usable limit
        return tracker.room_left() + DATA_W'($urandom_range(0, 1));
    endfunction

    function automatic cmd_item_t make_cmd(logic [CMD_W-1:0] code, int dst, int src,
            logic [DATA_W-1:0] amt, logic [DATA_W-1:0] prev, logic [DATA_W-1:0] owner);
        cmd_item_t it;
        it.command     = code;
        it.slot        = SLOT_W'(dst);
        it.source_slot = SLOT_W'(src);
        it.amount      = amt;
        it.old_amount  = prev;
        it.owner_tag   = owner;
        return it;
    endfunction

    // Mostly commands that suit the slot's present state, some pure noise
    function automatic cmd_item_t random_command(logic [DATA_W-1:0] span);
        cmd_item_t         it;
        int unsigned       roll;
        int                s;
        int                other;
        t_slot_state       st;
        logic [DATA_W-1:0] held;
        s     = $urandom_range(0, SLOT_COUNT_DEF - 1);
        other = $urandom_range(0, SLOT_COUNT_DEF - 1);
        it    = make_cmd(CMD_CLEAR, s, other, pick_amount(span), rand_word(), rand_word());
        st    = tracker.slot_st[s];
        held  = tracker.slot_bytes[s];
        roll  = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 15) begin
            it.command = CMD_W'($urandom_range(0, 15));
            // keep clears of big live slots from leaking into the total
            if (it.command == CMD_CLEAR && tracker.is_live(s) && held > SMALL_LEAK)
                it.command = CMD_RELEASE;
            return it;
        end
        case (st)
            SS_EMPTY, SS_RELEASED: begin
                if (roll < 40) begin
                    it.command = CMD_RESERVE;
                end else if (roll < 70) begin
                    it.command    = CMD_GROWTH;
                    it.old_amount = (roll < 64) ? up_to(it.amount) : it.amount + 1;
                end else if (roll < 85) begin
                    it.command = CMD_MOVE;
                end else if (roll < 95) begin
                    it.command = CMD_CLEAR;
                end else begin
                    it.command = CMD_COMMIT;
                end
            end
            SS_RESERVED: begin
                if (roll < 35) it.command = CMD_COMMIT;
                else if (roll < 50) it.command = CMD_TRANSFER;
                else if (roll < 65) it.command = CMD_ROLLBACK;
                else if (roll < 75) it.command = CMD_RELEASE;
                else if (roll < 90) begin
                    it.command     = CMD_MOVE;
                    it.slot        = SLOT_W'(other);
                    it.source_slot = SLOT_W'(s);
                end else if (roll < 95) it.command = CMD_RESERVE;
                else it.command = CMD_DOWNSIZE;
            end
            default: begin
                if (roll < 25) begin
                    it.command = CMD_DOWNSIZE;
                    it.amount  = ($urandom_range(0, 9) == 0) ? held + 1 : up_to(held);
                end else if (roll < 55) it.command = CMD_RELEASE;
                else if (roll < 70) it.command = CMD_TRANSFER;
                else if (roll < 90) begin
                    it.command     = CMD_MOVE;
                    it.slot        = SLOT_W'(other);
                    it.source_slot = SLOT_W'(s);
                end else if (roll < 95) it.command = CMD_ROLLBACK;
                else it.command = CMD_COMMIT;
            end
        endcase
        return it;
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic send_cmd(input cmd_item_t it);
        int gap;
        if (sent_count % BURST_WINDOW == 0) send_burst = ($urandom_range(0, 3) == 0);
        gap = send_burst ? 0 : int'($urandom_range(0, MAX_GAP));
        @(negedge i_clk);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.command     <= it.command;
        cmd_if.slot        <= it.slot;
        cmd_if.source_slot <= it.source_slot;
        cmd_if.amount      <= it.amount;
        cmd_if.old_amount  <= it.old_amount;
        cmd_if.owner_tag   <= it.owner_tag;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        tracker.note_command(it);
        sent_count++;
    endtask

    task automatic quiet_input();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
    endtask

    task automatic wait_replies();
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        tracker.set_register(idx, value);
    endtask

    task automatic apply_setting(input setting_t cfg);
        write_reg(CFG_BUDGET, cfg.budget);
        write_reg(CFG_ENFORCING, DATA_W'(cfg.enforcing));
        write_reg(CFG_HEAD_CAP, cfg.head_cap);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Give back every live slot so the next setting starts near zero
    task automatic release_live_slots();
        for (int s = 0; s < SLOT_COUNT_DEF; s++) begin
            if (tracker.is_live(s))
                send_cmd(make_cmd(CMD_RELEASE, s, 0, rand_word(), rand_word(), rand_word()));
        end
    endtask

    initial begin : stimulus
        setting_t plan [NUM_SETTINGS];
        setting_t gate;

        plan[0] = '{budget: '0, enforcing: 1'b0, head_cap: HEAD_CAP_RESET,
                    span: 64'd1 << 20};
        plan[1] = '{budget: 64'd1000000, enforcing: 1'b1, head_cap: HEAD_CAP_RESET,
                    span: 64'd200000};
        plan[2] = '{budget: 64'd10000, enforcing: 1'b1, head_cap: '0, span: 64'd3000};
        plan[3] = '{budget: ALL_ONES, enforcing: 1'b1, head_cap: ALL_ONES,
                    span: 64'd1 << 60};
        plan[4] = '{budget: '0, enforcing: 1'b1, head_cap: ALL_ONES, span: 64'd100};
        plan[5] = '{budget: 64'd100, enforcing: 1'b1, head_cap: ALL_ONES, span: 64'd8};
        plan[6] = '{budget: 64'd5000, enforcing: 1'b1, head_cap: 64'd37,
                    span: 64'd1500};
        plan[7] = '{budget: ALL_ONES, enforcing: 1'b0, head_cap: '0, span: 64'd1 << 62};
        gate    = '{budget: 64'd1000, enforcing: 1'b1, head_cap: HEAD_CAP_RESET,
                    span: 64'd100};

        // Known values on every input from time zero
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CFG_BUDGET;
        i_cfg_data         = '0;
        cmd_if.valid       = 1'b0;
        cmd_if.command     = CMD_RESERVE;
        cmd_if.slot        = '0;
        cmd_if.source_slot = '0;
        cmd_if.amount      = '0;
        cmd_if.old_amount  = '0;
        cmd_if.owner_tag   = '0;
        reply_if.ready     = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening under the reset setting: advisory, no limit
        send_cmd(make_cmd(CMD_RESERVE, 0, 0, '0, '0, '0));
        send_cmd(make_cmd(CMD_RESERVE, 0, 15, 64'd100, ALL_ONES, ALL_ONES));
        send_cmd(make_cmd(CMD_RESERVE, 0, 0, 64'd5, '0, '0));
        send_cmd(make_cmd(CMD_GROWTH, 1, 0, 64'd50, 64'd60, '0));
        send_cmd(make_cmd(CMD_GROWTH, 1, 0, 64'd60, 64'd50, '0));
        send_cmd(make_cmd(CMD_COMMIT, 0, 0, '0, '0, ALL_ONES));
        send_cmd(make_cmd(CMD_COMMIT, 2, 0, '0, '0, 64'd1));
        send_cmd(make_cmd(CMD_TRANSFER, 0, 0, '0, '0, 64'h5555_5555_5555_5555));
        send_cmd(make_cmd(CMD_TRANSFER, 1, 0, '0, '0, 64'hAAAA_AAAA_AAAA_AAAA));
        send_cmd(make_cmd(CMD_DOWNSIZE, 0, 0, 64'd40, '0, '0));
        send_cmd(make_cmd(CMD_DOWNSIZE, 0, 0, '0, '0, '0));
        send_cmd(make_cmd(CMD_DOWNSIZE, 0, 0, 64'd41, '0, '0));
        send_cmd(make_cmd(CMD_ROLLBACK, 0, 0, '0, '0, '0));
        send_cmd(make_cmd(CMD_ROLLBACK, 1, 0, '0, '0, '0));
        send_cmd(make_cmd(CMD_RELEASE, 0, 0, '0, '0, '0));
        send_cmd(make_cmd(CMD_MOVE, 3, 3, '0, '0, '0));
        send_cmd(make_cmd(CMD_RESERVE, 4, 0, 64'd7, '0, '0));
        send_cmd(make_cmd(CMD_MOVE, 15, 4, '0, '0, '0));
        send_cmd(make_cmd(CMD_MOVE, 5, 4, '0, '0, '0));
        // wrap past the top of the total, then fill it exactly
        send_cmd(make_cmd(CMD_RESERVE, 6, 0, ALL_ONES, '0, '0));
        send_cmd(make_cmd(CMD_RESERVE, 7, 0, ALL_ONES - 64'd7, '0, '0));
        send_cmd(make_cmd(CMD_RELEASE, 7, 0, '0, '0, '0));
        send_cmd(make_cmd(CMD_CLEAR, 6, 0, '0, '0, '0));
        send_cmd(make_cmd(CMD_CLEAR, 15, 0, '0, '0, '0));
        send_cmd(make_cmd(CMD_UNUSED_HI, 15, 15, ALL_ONES, ALL_ONES, ALL_ONES));
        send_cmd(make_cmd(CMD_UNUSED_LO, 0, 0, '0, '0, '0));

        // Enforcing: one byte past the limit, then exactly up to it
        quiet_input();
        wait_replies();
        apply_setting(gate);
        send_cmd(make_cmd(CMD_RESERVE, 8, 0, tracker.room_left() + 64'd1, '0, '0));
        send_cmd(make_cmd(CMD_RESERVE, 8, 0, tracker.room_left(), '0, '0));
        send_cmd(make_cmd(CMD_ROLLBACK, 8, 0, '0, '0, '0));

        // Random traffic under each setting in turn
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            release_live_slots();
            quiet_input();
            wait_replies();
            apply_setting(plan[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_cmd(random_command(plan[p].span));
                if (p == 1 && n == 50) hold_request = 1'b1;
                if (p == 3 && n == 60) begin
                    quiet_input();
                    wait_replies();
                end
            end
        end

        quiet_input();
        wait_replies();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.outstanding() != 0) begin
            $error("%0d replies never arrived", tracker.outstanding());
            tracker.mismatches++;
        end

        $display("Sent %0d commands over %0d admission settings after a directed opening",
                 sent_count, NUM_SETTINGS);
        $display("Replies: %0d ok, %0d advisory, %0d denied, %0d overflow, %0d invalid",
                 tracker.status_seen[RS_OK], tracker.status_seen[RS_ADVISORY],
                 tracker.status_seen[RS_DENIED], tracker.status_seen[RS_OVERFLOW],
                 tracker.status_seen[RS_INVALID]);
        if (tracker.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
